### hw/rtl/heightmap_box_smooth_3x3_unit_assert.svh
// Assertion macros for the RTL of the height map box smoother.
// Each use expects clk_i and rst_ni in the scope of the module.
`ifndef HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_ASSERT_SVH
`define HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define HBS3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HBS3_ASSERT_NEXT(lbl, pre, post, msg) \
  `HBS3_ASSERT(lbl, (pre) |=> (post), msg)
`else
`define HBS3_ASSERT(lbl, prop, msg)
`define HBS3_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### hw/rtl/hbs3_pkg.sv
package hbs3_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned CfgBits     = 11;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned MaxAddrBits = 12;
  localparam int unsigned MaxHeight   = 1024;
  localparam int unsigned QueueDepth  = 4;

  // Column sums of three samples and the window sum of nine samples.
  localparam int unsigned ColBits   = SampleBits + 2;
  localparam int unsigned SumBits   = SampleBits + 4;
  // Magnitude of the window sum plus the rounding offset.
  localparam int unsigned MagBits   = SampleBits + 3;
  localparam int unsigned RecipBits = MagBits - 3;
  localparam logic [RecipBits-1:0] RecipNine =
    RecipBits'((64'd1 << MagBits) / 64'd9);

  localparam logic [CfgIdxBits-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgFrameHeight = 2'd1;

  typedef struct packed {
    logic signed [SampleBits-1:0] height_sample;
    logic                         is_flush;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] smoothed_height;
    logic                         frame_last;
  } out_word_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic [MaxAddrBits-1:0]       addr;
    logic signed [SampleBits-1:0] sample;
    logic                         emit;
    logic                         border;
    logic                         last;
  } entry_t;

endpackage

### hw/rtl/hbs3_front.sv
module hbs3_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hbs3_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [hbs3_pkg::CfgBits-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  input  hbs3_pkg::in_word_t                  in_word_i,
  input  logic                                full_i,
  output logic                                push_o,
  output hbs3_pkg::entry_t                    entry_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CB = hbs3_pkg::CfgBits;

  logic [CB-1:0] width_q, width_d, height_q, height_d;
  logic [AW-1:0] x_q, x_d;
  logic [CB-1:0] y_q, y_d;

  logic [CB-1:0] w_eff, h_eff;
  logic [AW-1:0] x_eff;
  logic [CB:0]   h_plus1;
  logic          x0, x1, emit, last, row_top, row_bot, x_wrap, accept;

  always_comb begin
    if (width_q < CB'(3)) begin
      w_eff = CB'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = CB'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q < CB'(3)) begin
      h_eff = CB'(3);
    end else if (32'(height_q) > hbs3_pkg::MaxHeight) begin
      h_eff = CB'(hbs3_pkg::MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // A result in column 0 belongs to the last column of the row before.
  assign x_eff   = (32'(x_q) >= 32'(w_eff)) ? '0 : x_q;
  assign x0      = (x_eff == '0);
  assign x1      = (x_eff == AW'(1));
  assign h_plus1 = {1'b0, h_eff} + (CB+1)'(1);
  assign emit    = (y_q >= CB'(2)) || ((y_q == CB'(1)) && !x0);
  assign row_top = x0 ? (y_q == CB'(2)) : (y_q == CB'(1));
  assign row_bot = x0 ? ({1'b0, y_q} == h_plus1) : (y_q == h_eff);
  assign last    = x0 && ({1'b0, y_q} == h_plus1);
  assign x_wrap  = (32'(x_eff) + 32'd1) >= 32'(w_eff);
  assign accept  = in_valid_i && !full_i;

  assign push_o         = accept;
  assign entry_o.addr   = hbs3_pkg::MaxAddrBits'(x_eff);
  assign entry_o.sample = in_word_i.is_flush ? '0 : in_word_i.height_sample;
  assign entry_o.emit   = emit;
  assign entry_o.border = row_top || row_bot || x0 || x1;
  assign entry_o.last   = last;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    x_d      = x_q;
    y_d      = y_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        hbs3_pkg::CfgFrameWidth: begin
          width_d = cfg_wdata_i;
          x_d     = '0;
          y_d     = '0;
        end
        hbs3_pkg::CfgFrameHeight: begin
          height_d = cfg_wdata_i;
          x_d      = '0;
          y_d      = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (emit && last) begin
        x_d = '0;
        y_d = '0;
      end else if (x_wrap) begin
        x_d = '0;
        y_d = y_q + CB'(1);
      end else begin
        x_d = x_eff + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CB'(64);
      height_q <= CB'(64);
      x_q      <= '0;
      y_q      <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      x_q      <= x_d;
      y_q      <= y_d;
    end
  end

endmodule

### hw/rtl/hbs3_queue.sv
`include "heightmap_box_smooth_3x3_unit_assert.svh"

module hbs3_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hbs3_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_valid_o,
  output hbs3_pkg::entry_t head_o
);

  localparam int unsigned Depth   = hbs3_pkg::QueueDepth;
  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = PtrBits + 1;

  hbs3_pkg::entry_t     mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   count_q, count_d;

  assign full_o       = (count_q == CntBits'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntBits'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `HBS3_ASSERT(a_count_range, count_q <= CntBits'(Depth), "queue count beyond depth")
  `HBS3_ASSERT(a_no_pop_empty, pop_i |-> (count_q != '0), "pop from an empty queue")
  `HBS3_ASSERT(a_no_push_full, push_i |-> !full_o, "push into a full queue")
  `HBS3_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count did not step up")

endmodule

### hw/rtl/hbs3_back.sv
module hbs3_back #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  hbs3_pkg::entry_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output hbs3_pkg::out_word_t out_word_o,
  input  logic                out_stall_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned SB = hbs3_pkg::SampleBits;
  localparam int unsigned CW = hbs3_pkg::ColBits;
  localparam int unsigned TW = hbs3_pkg::SumBits;
  localparam int unsigned MW = hbs3_pkg::MagBits;
  localparam int unsigned RW = hbs3_pkg::RecipBits;

  logic adv, b_wr;
  logic [AW-1:0] rd_addr;

  // Line stores: older row and newer row, same address for both.
  logic signed [SB-1:0] older_mem [MAX_WIDTH];
  logic signed [SB-1:0] newer_mem [MAX_WIDTH];
  logic signed [SB-1:0] older_rd_q, newer_rd_q;

  // Stage B: window update.
  logic                 b_valid_q;
  logic [AW-1:0]        b_addr_q;
  logic signed [SB-1:0] b_s_q, fwd_top_q, fwd_mid_q;
  logic                 b_emit_q, b_border_q, b_last_q, b_fwd_q;
  logic signed [SB-1:0] top_b, mid_b, center_q;
  logic signed [CW-1:0] col_new, cs1_q, cs2_q;

  // Stage C: window sum.
  logic                 c_valid_q, c_border_q, c_last_q;
  logic signed [CW-1:0] c_t0_q, c_t1_q, c_t2_q;
  logic signed [SB-1:0] c_center_q;
  logic signed [TW-1:0] c_total;
  logic [TW-1:0]        c_mag;
  logic [MW-1:0]        c_a;

  // Stage D: reciprocal multiply.
  logic                 d_valid_q, d_border_q, d_last_q, d_neg_q;
  logic [MW-1:0]        d_a_q;
  logic signed [SB-1:0] d_center_q;

  // Stage E: quotient correction and output select.
  logic                 e_valid_q, e_border_q, e_last_q, e_neg_q;
  logic [MW-1:0]        e_a_q;
  logic [MW+RW-1:0]     e_prod_q;
  logic signed [SB-1:0] e_center_q;
  logic [RW-1:0]        e_qest, e_quot;
  logic [MW-1:0]        e_rem;
  logic [SB-1:0]        e_mean;

  logic                 out_valid_q;
  hbs3_pkg::out_word_t  out_word_q;

  assign adv     = !out_valid_q || !out_stall_i;
  assign pop_o   = adv && head_valid_i;
  assign b_wr    = adv && b_valid_q;
  assign rd_addr = head_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      older_rd_q <= older_mem[rd_addr];
      newer_rd_q <= newer_mem[rd_addr];
    end
    if (b_wr) begin
      older_mem[b_addr_q] <= mid_b;
      newer_mem[b_addr_q] <= b_s_q;
    end
  end

  // A word read in the same cycle its address is written (column 0 right
  // after the end of a frame) takes the values being written instead.
  assign top_b   = b_fwd_q ? fwd_top_q : older_rd_q;
  assign mid_b   = b_fwd_q ? fwd_mid_q : newer_rd_q;
  assign col_new = CW'(top_b) + CW'(mid_b) + CW'(b_s_q);

  assign c_total = TW'(c_t0_q) + TW'(c_t1_q) + TW'(c_t2_q);
  assign c_mag   = c_total[TW-1] ? (~c_total + TW'(1)) : c_total;
  assign c_a     = MW'(c_mag) + MW'(4);

  // The estimate is low by at most one; a single compare fixes it.
  assign e_qest = e_prod_q[MW+RW-1:MW];
  assign e_rem  = e_a_q - (MW'({e_qest, 3'b000}) + MW'(e_qest));
  assign e_quot = (e_rem >= MW'(9)) ? (e_qest + RW'(1)) : e_qest;
  assign e_mean = e_neg_q ? (~SB'(e_quot) + SB'(1)) : SB'(e_quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q   <= pop_o;
      c_valid_q   <= b_valid_q && b_emit_q;
      d_valid_q   <= c_valid_q;
      e_valid_q   <= d_valid_q;
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_addr_q   <= rd_addr;
      b_s_q      <= head_i.sample;
      b_emit_q   <= head_i.emit;
      b_border_q <= head_i.border;
      b_last_q   <= head_i.last;
      b_fwd_q    <= b_wr && (b_addr_q == rd_addr);
      fwd_top_q  <= mid_b;
      fwd_mid_q  <= b_s_q;
    end
    if (b_wr) begin
      cs1_q    <= cs2_q;
      cs2_q    <= col_new;
      center_q <= mid_b;
    end
    if (adv) begin
      c_t0_q     <= cs1_q;
      c_t1_q     <= cs2_q;
      c_t2_q     <= col_new;
      c_center_q <= center_q;
      c_border_q <= b_border_q;
      c_last_q   <= b_last_q;

      d_a_q      <= c_a;
      d_neg_q    <= c_total[TW-1];
      d_center_q <= c_center_q;
      d_border_q <= c_border_q;
      d_last_q   <= c_last_q;

      e_prod_q   <= (MW+RW)'(d_a_q) * (MW+RW)'(hbs3_pkg::RecipNine);
      e_a_q      <= d_a_q;
      e_neg_q    <= d_neg_q;
      e_center_q <= d_center_q;
      e_border_q <= d_border_q;
      e_last_q   <= d_last_q;

      out_word_q <= '{smoothed_height: e_border_q ? e_center_q : $signed(e_mean),
                      frame_last:      e_last_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### hw/rtl/heightmap_box_smooth_3x3_unit.sv
// Streaming 3x3 box smoother for a raster height map in signed Q8.8. It takes
// one word per clock cycle while in_stall_o is low and gives one result per
// cycle at full rate while the output is not stalled; the front classifies
// each word, a four-word queue parts it from the back, and the back reads the
// two line stores (one read and one write port each, read data registered),
// updates the window, sums, and divides by nine through a reciprocal multiply
// with one correction step. A word popped from the queue passes through stages
// B, C, D and E before its result reaches the output register. A stall on the
// output while a result is held freezes the whole back; the input stalls only
// once the queue has filled behind it. The result for sample p is released by
// word p+width+1, so a frame needs width+1 flush words to drain; frame_last
// marks its final result. Writing frame_width or frame_height restarts the
// frame and is allowed only while the block is idle. The line stores are not
// cleared after reset and need no clearing pass.
module heightmap_box_smooth_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hbs3_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [hbs3_pkg::CfgBits-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  hbs3_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output hbs3_pkg::out_word_t              out_word_o
);

  logic             push, full, pop, head_valid;
  hbs3_pkg::entry_t entry, head;

  assign in_stall_o = full;

  hbs3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  hbs3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .pop_i       (pop),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  hbs3_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule
